// File: rtl/core/gait_motion_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Gait motion sequencer assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAIT_MOTION_SEQUENCER_UNIT_MACROS_SVH
`define GAIT_MOTION_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define GMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gms assertion failed");
// Implication checked in the cycle after the antecedent.
`define GMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gms assertion failed");
`else
`define GMS_ASSERT_SAME(lbl, ante, cons)
`define GMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/gms_pkg.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer package
// Types, codes and sizing constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gms_pkg;

  localparam int StepWidth = 8;
  localparam int CntWidth  = 8;
  localparam int CmpWidth  = (StepWidth > CntWidth) ? StepWidth : CntWidth;
  localparam logic [StepWidth-1:0] StepMax = {StepWidth{1'b1}};

  typedef enum logic [3:0] {
    OP_TICK    = 4'd0,
    OP_STAND   = 4'd1,
    OP_WALK    = 4'd2,
    OP_STOP    = 4'd3,
    OP_TURN_L  = 4'd4,
    OP_TURN_R  = 4'd5,
    OP_TRACK_L = 4'd6,
    OP_TRACK_R = 4'd7,
    OP_TRACK_F = 4'd8,
    OP_TRACK_B = 4'd9
  } opcode_e;

  typedef enum logic [3:0] {
    MV_STAND    = 4'd0,
    MV_START    = 4'd1,
    MV_FORWARD  = 4'd2,
    MV_STOPWALK = 4'd3,
    MV_TURN_L   = 4'd4,
    MV_TURN_R   = 4'd5,
    MV_TRACK_L  = 4'd6,
    MV_TRACK_R  = 4'd7,
    MV_TRACK_F  = 4'd8,
    MV_TRACK_B  = 4'd9
  } motion_e;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_STAND   = 4'd1,
    ST_START   = 4'd2,
    ST_FORWARD = 4'd3,
    ST_STOP    = 4'd4,
    ST_TURN_L  = 4'd5,
    ST_TURN_R  = 4'd6,
    ST_TRACK_L = 4'd7,
    ST_TRACK_R = 4'd8,
    ST_TRACK_F = 4'd9,
    ST_TRACK_B = 4'd10
  } walk_state_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_BUSY     = 2'd1,
    STS_BAD_CNT  = 2'd2,
    STS_IDLE_ALR = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]          opcode;
    logic [CntWidth-1:0] step_count;
    logic                motion_playing;
  } item_t;

  typedef struct packed {
    logic       start_motion;
    logic [3:0] motion_id;
    logic       abort_motion;
    logic [1:0] status;
    logic [3:0] walk_state;
    logic       busy_res;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/gms_in_if.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer input channel
// Valid/ready channel carrying one event word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gms_in_if import gms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [3:0]          opcode;
  logic [CntWidth-1:0] step_count;
  logic                motion_playing;

  modport source (output valid, output opcode, output step_count, output motion_playing,
                  input ready);
  modport sink   (input valid, input opcode, input step_count, input motion_playing,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/gms_out_if.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer output channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gms_out_if ();
  logic       valid;
  logic       ready;
  logic       start_motion;
  logic [3:0] motion_id;
  logic       abort_motion;
  logic [1:0] status;
  logic [3:0] walk_state;
  logic       busy_res;

  modport source (output valid, output start_motion, output motion_id, output abort_motion,
                  output status, output walk_state, output busy_res, input ready);
  modport sink   (input valid, input start_motion, input motion_id, input abort_motion,
                  input status, input walk_state, input busy_res, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gms_in_stage.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer input register
// Captures one event word and holds it until the sequencer core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_in_stage import gms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gms_in_if.sink     in_ch,
  input  wire logic  take_i,
  output item_t      item_o,
  output logic       valid_o
);

  logic  valid_q;
  item_t item_q;
  logic  load;

  assign in_ch.ready = !valid_q || take_i;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.opcode         <= in_ch.opcode;
      item_q.step_count     <= in_ch.step_count;
      item_q.motion_playing <= in_ch.motion_playing;
    end
  end

  assign item_o  = item_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: rtl/core/gms_seq_core.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer core
// Holds the gait state, remaining steps and pending stop, and works out the
// result of one event word in a single pass of logic.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gait_motion_sequencer_unit_macros.svh"

module gms_seq_core import gms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_en_i,
  input  wire item_t item_i,
  output result_t    res_o
);

  walk_state_e          mode_q, mode_d;
  logic [StepWidth-1:0] steps_q, steps_d;
  logic                 stop_q, stop_d;

  logic                 playing;
  logic                 start;
  motion_e              motion;
  logic                 abort_m;
  status_e              status;
  logic [CmpWidth-1:0]  walk_n;

  assign playing = item_i.motion_playing;
  // Requested count minus the starting step; saturated to the counter range where it is loaded.
  assign walk_n  = CmpWidth'(item_i.step_count) - CmpWidth'(1);

  always_comb begin
    mode_d  = mode_q;
    steps_d = steps_q;
    stop_d  = stop_q;
    start   = 1'b0;
    motion  = MV_STAND;
    abort_m = 1'b0;
    status  = STS_OK;
    case (item_i.opcode)
      OP_TICK: begin
        if (!playing) begin
          case (mode_q)
            ST_STAND: begin
              stop_d = 1'b0;
              mode_d = ST_IDLE;
            end
            ST_START, ST_FORWARD: begin
              start = 1'b1;
              if (!stop_q && (steps_q != '0)) begin
                steps_d = steps_q - StepWidth'(1);
                motion  = MV_FORWARD;
              end else begin
                motion  = MV_STOPWALK;
              end
            end
            ST_STOP: begin
              stop_d  = 1'b0;
              steps_d = '0;
              mode_d  = ST_IDLE;
            end
            ST_TURN_L, ST_TURN_R, ST_TRACK_L, ST_TRACK_R: begin
              mode_d = ST_IDLE;
            end
            ST_TRACK_F, ST_TRACK_B: begin
              stop_d = 1'b0;
              start  = 1'b1;
              motion = MV_STAND;
            end
            default: begin
            end
          endcase
        end
      end
      OP_STAND: begin
        if (playing) begin
          status = STS_BUSY;
        end else begin
          stop_d  = 1'b0;
          steps_d = '0;
          start   = 1'b1;
          motion  = MV_STAND;
        end
      end
      OP_WALK: begin
        if (item_i.step_count == '0) begin
          status = STS_BAD_CNT;
        end else if (playing || (mode_q != ST_IDLE)) begin
          status = STS_BUSY;
        end else begin
          stop_d  = 1'b0;
          steps_d = (walk_n > CmpWidth'(StepMax)) ? StepMax : walk_n[StepWidth-1:0];
          start   = 1'b1;
          motion  = MV_START;
        end
      end
      OP_STOP: begin
        steps_d = '0;
        if (playing && (mode_q inside {ST_TRACK_L, ST_TRACK_R})) begin
          // Tracking turns are cut off at once and the robot stands.
          abort_m = 1'b1;
          stop_d  = 1'b0;
          start   = 1'b1;
          motion  = MV_STAND;
        end else if (playing) begin
          stop_d = 1'b1;
        end else if (mode_q == ST_IDLE) begin
          stop_d = 1'b0;
          status = STS_IDLE_ALR;
        end else begin
          stop_d = 1'b1;
          start  = 1'b1;
          motion = MV_STOPWALK;
        end
      end
      OP_TURN_L, OP_TURN_R, OP_TRACK_L, OP_TRACK_R, OP_TRACK_F, OP_TRACK_B: begin
        if (playing || (mode_q != ST_IDLE)) begin
          status = STS_BUSY;
        end else begin
          stop_d  = 1'b0;
          steps_d = '0;
          start   = 1'b1;
          motion  = motion_e'(item_i.opcode);
        end
      end
      default: begin
      end
    endcase
    // Every motion has a state of its own, numbered one above it.
    if (start) begin
      mode_d = walk_state_e'(motion + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ST_IDLE;
      steps_q <= '0;
      stop_q  <= 1'b0;
    end else if (step_en_i) begin
      mode_q  <= mode_d;
      steps_q <= steps_d;
      stop_q  <= stop_d;
    end
  end

  always_comb begin
    res_o.start_motion = start;
    res_o.motion_id    = start ? motion : 4'd0;
    res_o.abort_motion = abort_m;
    res_o.status       = status;
    res_o.walk_state   = mode_d;
    res_o.busy_res     = playing || start || (mode_d != ST_IDLE);
  end

  `GMS_ASSERT_NEXT(a_abort_stands, step_en_i && abort_m, mode_q == ST_STAND)
  `GMS_ASSERT_NEXT(a_stop_clears_steps, step_en_i && (item_i.opcode == OP_STOP),
                   steps_q == '0)
  `GMS_ASSERT_NEXT(a_tick_never_adds, step_en_i && (item_i.opcode == OP_TICK),
                   steps_q <= $past(steps_q))
  `GMS_ASSERT_SAME(a_abort_only_on_stop, abort_m,
                   start && (item_i.opcode == OP_STOP) && playing)

endmodule

`default_nettype wire

// File: rtl/core/gms_out_stage.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gms_out_stage import gms_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire result_t res_i,
  input  wire logic    load_i,
  output logic         room_o,
  gms_out_if.source    out_ch
);

  logic    valid_q;
  result_t res_q;

  assign room_o = !valid_q || out_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_ch.valid        = valid_q;
  assign out_ch.start_motion = res_q.start_motion;
  assign out_ch.motion_id    = res_q.motion_id;
  assign out_ch.abort_motion = res_q.abort_motion;
  assign out_ch.status       = res_q.status;
  assign out_ch.walk_state   = res_q.walk_state;
  assign out_ch.busy_res     = res_q.busy_res;

endmodule

`default_nettype wire

// File: rtl/core/gait_motion_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Gait motion sequencer unit
// Eleven-state gait sequencer: one event word in, one result word out.
//
//   Channel  Dir  Payload
//   in_ch    in   opcode, step_count, motion_playing
//   out_ch   out  start_motion, motion_id, abort_motion, status, walk_state,
//                 busy_res
//
// A word is registered on entry, processed against the gait state in one
// pass of logic and registered again on exit; one new word goes through
// every cycle while the output is taken. The state is updated as each word
// is taken, so words follow each other directly.
// Reset clears the gait state to idle with no steps and no pending stop.
// A stalled output holds its word; the input keeps taking one more word.
// ----------------------------------------------------------------------------
`default_nettype none

module gait_motion_sequencer_unit import gms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gms_in_if.sink     in_ch,
  gms_out_if.source  out_ch
);

  item_t   item;
  logic    item_valid;
  logic    room;
  logic    step_en;
  result_t res;

  assign step_en = item_valid && room;

  gms_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .take_i  (step_en),
    .item_o  (item),
    .valid_o (item_valid)
  );

  gms_seq_core u_seq_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (item),
    .res_o     (res)
  );

  gms_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .res_i  (res),
    .load_i (step_en),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: tb/gait_motion_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gait motion sequencer unit testbench
// Drives event words into the sequencer and checks every result word against
// a behavioural predictor of the gait state, the remaining steps and the
// pending stop, or against the opening's own expectation where it gives one.
// A short scripted opening covers each command and corner case; a long run
// of state-aware random words follows, with random gaps on both channels.
// ----------------------------------------------------------------------------

module gait_motion_sequencer_unit_tb;
  import gms_pkg::*;

  localparam int RandWords   = 1700;
  localparam int IdlePct     = 13;
  localparam int CalmFrom    = 800;
  localparam int CalmTo      = 1800;
  localparam int DrainCycles = 8;
  localparam int StallLimit  = 2000;
  localparam logic [3:0] OpUnusedLo = 4'hA;
  localparam logic [3:0] OpUnusedHi = 4'hF;

  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } script_row_t;

  logic clk_i;
  logic rst_ni;

  gms_in_if  in_ch ();
  gms_out_if out_ch ();

  gait_motion_sequencer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state, advanced once per accepted word.
  walk_state_e          gait_state;
  logic [StepWidth-1:0] steps_remaining;
  logic                 stop_queued;

  result_t pending_results[$];
  int      mismatch_cnt = 0;
  int      cycle_cnt    = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic bit calm_window();
    return cycle_cnt >= CalmFrom && cycle_cnt < CalmTo;
  endfunction

  task automatic predict_gait(input item_t w, output result_t r);
    logic    start;
    motion_e mv;
    logic    abort_m;
    status_e sts;
    logic    playing;
    start   = 1'b0;
    mv      = MV_STAND;
    abort_m = 1'b0;
    sts     = STS_OK;
    playing = w.motion_playing;
    case (w.opcode)
      OP_TICK: begin
        if (!playing) begin
          case (gait_state)
            ST_STAND: begin
              stop_queued = 1'b0;
              gait_state  = ST_IDLE;
            end
            ST_START, ST_FORWARD: begin
              start = 1'b1;
              if (!stop_queued && steps_remaining != '0) begin
                steps_remaining = steps_remaining - StepWidth'(1);
                mv = MV_FORWARD;
              end else begin
                mv = MV_STOPWALK;
              end
            end
            ST_STOP: begin
              stop_queued     = 1'b0;
              steps_remaining = '0;
              gait_state      = ST_IDLE;
            end
            ST_TURN_L, ST_TURN_R, ST_TRACK_L, ST_TRACK_R: begin
              gait_state = ST_IDLE;
            end
            ST_TRACK_F, ST_TRACK_B: begin
              stop_queued = 1'b0;
              start       = 1'b1;
              mv          = MV_STAND;
            end
            default: ;
          endcase
        end
      end
      OP_STAND: begin
        if (playing) begin
          sts = STS_BUSY;
        end else begin
          stop_queued     = 1'b0;
          steps_remaining = '0;
          start           = 1'b1;
          mv              = MV_STAND;
        end
      end
      OP_WALK: begin
        if (w.step_count == '0) begin
          sts = STS_BAD_CNT;
        end else if (playing || gait_state != ST_IDLE) begin
          sts = STS_BUSY;
        end else begin
          stop_queued = 1'b0;
          // The counter saturates if the requested count does not fit.
          if (int'(w.step_count) - 1 > int'(StepMax)) steps_remaining = StepMax;
          else steps_remaining = StepWidth'(int'(w.step_count) - 1);
          start = 1'b1;
          mv    = MV_START;
        end
      end
      OP_STOP: begin
        if (playing && (gait_state inside {ST_TRACK_L, ST_TRACK_R})) begin
          abort_m         = 1'b1;
          stop_queued     = 1'b0;
          steps_remaining = '0;
          start           = 1'b1;
          mv              = MV_STAND;
        end else if (playing) begin
          stop_queued     = 1'b1;
          steps_remaining = '0;
        end else if (gait_state == ST_IDLE) begin
          stop_queued     = 1'b0;
          steps_remaining = '0;
          sts             = STS_IDLE_ALR;
        end else begin
          stop_queued     = 1'b1;
          steps_remaining = '0;
          start           = 1'b1;
          mv              = MV_STOPWALK;
        end
      end
      OP_TURN_L, OP_TURN_R, OP_TRACK_L, OP_TRACK_R, OP_TRACK_F, OP_TRACK_B: begin
        if (playing || gait_state != ST_IDLE) begin
          sts = STS_BUSY;
        end else begin
          stop_queued     = 1'b0;
          steps_remaining = '0;
          start           = 1'b1;
          mv              = motion_e'(w.opcode);
        end
      end
      default: ;
    endcase
    // Each motion maps onto the state numbered one above it.
    if (start) gait_state = walk_state_e'(mv + 4'd1);
    r.start_motion = start;
    r.motion_id    = mv;
    r.abort_motion = abort_m;
    r.status       = sts;
    r.walk_state   = gait_state;
    r.busy_res     = playing || start || gait_state != ST_IDLE;
  endtask

  function automatic script_row_t plan_word(logic [3:0] op, int cnt, bit play);
    script_row_t row;
    row.word.opcode         = op;
    row.word.step_count     = cnt[CntWidth-1:0];
    row.word.motion_playing = play;
    row.typed               = 1'b0;
    row.want                = '0;
    return row;
  endfunction

  function automatic script_row_t plan_checked(logic [3:0] op, int cnt, bit play, bit st,
                                               motion_e mv, status_e sts, walk_state_e ws,
                                               bit busy);
    script_row_t row;
    row                   = plan_word(op, cnt, play);
    row.typed             = 1'b1;
    row.want.start_motion = st;
    row.want.motion_id    = mv;
    row.want.abort_motion = 1'b0;
    row.want.status       = sts;
    row.want.walk_state   = ws;
    row.want.busy_res     = busy;
    return row;
  endfunction

  // Random words lean on the current gait state so that walks, turns and
  // tracking runs play out to their ends, with stray and rejected words mixed in.
  function automatic item_t pick_word();
    item_t w;
    int    roll;
    int    sub;
    w.step_count     = CntWidth'($urandom);
    w.motion_playing = 1'($urandom_range(1, 0));
    roll             = $urandom_range(99);
    sub              = $urandom_range(99);
    if (roll < 3) begin
      w.opcode = 4'($urandom_range(OpUnusedHi, OpUnusedLo));
    end else if (gait_state == ST_IDLE) begin
      if (roll < 40) begin
        w.opcode         = OP_WALK;
        w.motion_playing = ($urandom_range(99) < 15);
        if (sub < 6) w.step_count = '0;
        else if (sub < 85) w.step_count = CntWidth'($urandom_range(6, 1));
      end else if (roll < 70) begin
        w.opcode         = 4'($urandom_range(OP_TRACK_B, OP_TURN_L));
        w.motion_playing = ($urandom_range(99) < 15);
      end else if (roll < 80) begin
        w.opcode = OP_STAND;
      end else if (roll < 88) begin
        w.opcode = OP_STOP;
      end else begin
        w.opcode = OP_TICK;
      end
    end else begin
      if (roll < 80) w.opcode = OP_TICK;
      else if (roll < 88) w.opcode = OP_STOP;
      else w.opcode = 4'($urandom_range(OP_TRACK_B, OP_STAND));
    end
    return w;
  endfunction

  task automatic send_word(input item_t w, input bit typed, input result_t want);
    result_t pred;
    while (!calm_window() && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= w.opcode;
    in_ch.step_count     <= w.step_count;
    in_ch.motion_playing <= w.motion_playing;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_gait(w, pred);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_sink
    result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got state %0d status %0d",
                 $time, out_ch.walk_state, out_ch.status);
        mismatch_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("start_motion", 4'(want.start_motion), 4'(out_ch.start_motion));
        check_field("motion_id", want.motion_id, out_ch.motion_id);
        check_field("abort_motion", 4'(want.abort_motion), 4'(out_ch.abort_motion));
        check_field("status", 4'(want.status), 4'(out_ch.status));
        check_field("walk_state", want.walk_state, out_ch.walk_state);
        check_field("busy_res", 4'(want.busy_res), 4'(out_ch.busy_res));
      end
    end
    out_ch.ready <= rst_ni && (calm_window() || $urandom_range(99) >= IdlePct);
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no word moved for %0d cycles", $time, StallLimit);
    $display("gait_motion_sequencer_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    script_row_t opening[$];
    int          counted;
    item_t       w;
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_TICK;
    in_ch.step_count     = '0;
    in_ch.motion_playing = 1'b0;
    out_ch.ready         = 1'b0;
    gait_state           = ST_IDLE;
    steps_remaining      = '0;
    stop_queued          = 1'b0;
    counted              = 0;

    opening.push_back(plan_checked(OP_TICK, 0, 0, 0, MV_STAND, STS_OK, ST_IDLE, 0));
    opening.push_back(plan_checked(OP_STOP, 0, 0, 0, MV_STAND, STS_IDLE_ALR, ST_IDLE, 0));
    // A zero count is refused before the busy test is made.
    opening.push_back(plan_checked(OP_WALK, 0, 1, 0, MV_STAND, STS_BAD_CNT, ST_IDLE, 1));
    opening.push_back(plan_checked(OpUnusedHi, 255, 1, 0, MV_STAND, STS_OK, ST_IDLE, 1));
    opening.push_back(plan_checked(OP_WALK, 255, 0, 1, MV_START, STS_OK, ST_START, 1));
    opening.push_back(plan_word(OP_TICK, 0, 1));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_checked(OP_WALK, 5, 1, 0, MV_STAND, STS_BUSY, ST_FORWARD, 1));
    opening.push_back(plan_word(OP_STOP, 0, 1));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TRACK_L, 0, 0));
    opening.push_back(plan_word(OP_STOP, 0, 1));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TRACK_R, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TRACK_F, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_checked(OP_STAND, 0, 1, 0, MV_STAND, STS_BUSY, ST_STAND, 1));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TRACK_B, 0, 0));
    opening.push_back(plan_word(OP_STAND, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TURN_L, 0, 0));
    opening.push_back(plan_word(OP_STOP, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));
    opening.push_back(plan_word(OP_TURN_R, 0, 0));
    opening.push_back(plan_word(OP_TICK, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) send_word(opening[i].word, opening[i].typed, opening[i].want);

    while (counted < RandWords) begin
      w = pick_word();
      if (w.opcode <= OP_TRACK_B) counted++;
      send_word(w, 1'b0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("gait_motion_sequencer_unit verification clean");
    end else begin
      $display("gait_motion_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
